FILE: src/tkop_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tkop_pkg;

  localparam int MAX_KEEP = 32;
  localparam int MAX_LEN  = 1024;

  localparam int VALUE_W = 18;
  localparam int POS_W   = 10;
  localparam int KC_W    = 6;
  localparam int CNT_W   = $clog2(MAX_KEEP + 1);
  localparam int IDX_W   = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int ARR_W   = $clog2(MAX_LEN + 1);

  // min tree: groups reduced before its register, group minima reduced after it
  localparam int GROUP_SIZE = 8;
  localparam int NUM_GROUPS = (MAX_KEEP + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [POS_W-1:0]          pos_t;
  typedef logic [CNT_W-1:0]          count_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [ARR_W-1:0]          arrival_t;
  typedef logic [KC_W-1:0]           kc_t;

  // empty cells show the largest code so they never win the minimum
  localparam value_t KEY_FILL = {1'b0, {(VALUE_W-1){1'b1}}};

  typedef struct packed {
    logic occupied;
    logic load;
    logic shift;
  } cell_ctrl_t;

  function automatic value_t min2(value_t a, value_t b);
    return (b < a) ? b : a;
  endfunction

endpackage

`default_nettype wire

FILE: src/top_k_order_preserving_select.sv
// Flow: an appended or ignored item is handled in its accept cycle; one that meets a full
//   store passes accept, min tree register, then compare and close-up. An end item
//   drains the store from cell 0, n words for n kept values, one per cycle unless
//   out_stall holds it. in_stall holds off new items during a replacement or drain.
// Reset: rst (sync, active high) clears state, count and arrival counter and sets
//   keep_count to 1; cell contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module top_k_order_preserving_select (
  input  wire                  clk,
  input  wire                  rst,
  // config
  input  wire                  cfg_write,
  input  tkop_pkg::kc_t        cfg_data,
  // input words
  input  wire                  in_valid,
  output logic                 in_stall,
  input  tkop_pkg::value_t     sample_value,
  input  wire                  end_of_set,
  // output words
  output logic                 out_valid,
  input  wire                  out_stall,
  output tkop_pkg::value_t     chosen_value,
  output tkop_pkg::pos_t       chosen_position,
  output logic                 final_result
);
  import tkop_pkg::*;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_SCAN    = 2'd1;  // min tree first stage
  localparam logic [1:0] ST_REPLACE = 2'd2;  // min known, drop and close up
  localparam logic [1:0] ST_DRAIN   = 2'd3;  // emit cell 0, shift left

  logic [1:0] state, state_next;
  kc_t        keep_count;
  count_t     count, count_next;
  arrival_t   arrival, arrival_next;

  // word held while the store searches its minimum
  value_t     hold_value;
  pos_t       hold_pos;
  logic       hold_last;

  // cell chain
  cell_ctrl_t ctrl      [MAX_KEEP];
  value_t     cell_value[MAX_KEEP];
  pos_t       cell_pos  [MAX_KEEP];
  value_t     cell_key  [MAX_KEEP];
  logic       cell_hit  [MAX_KEEP];
  value_t     floor_min;

  // ---------------------------------------------------------------------------
  // Config register and effective k (zero acts as 1, clipped at MAX_KEEP)
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_count <= kc_t'(1);
    end else if (cfg_write) begin
      keep_count <= cfg_data;
    end
  end

  logic [7:0] kc_wide;
  count_t     k_eff;

  always_comb begin
    kc_wide = 8'(keep_count);
    if (kc_wide == 8'd0) begin
      k_eff = count_t'(1);
    end else if (kc_wide > 8'(MAX_KEEP)) begin
      k_eff = count_t'(MAX_KEEP);
    end else begin
      k_eff = count_t'(kc_wide);
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake decode
  // ---------------------------------------------------------------------------
  logic accept, take, room, append, do_replace, drain_take;
  idx_t low;

  assign in_stall   = (state != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign take       = (arrival < arrival_t'(MAX_LEN));  // past MAX_LEN: ignored
  assign room       = (count < k_eff);                  // k_eff <= MAX_KEEP
  assign append     = accept && take && room;
  assign do_replace = (state == ST_REPLACE) && (hold_value > floor_min);
  assign drain_take = (state == ST_DRAIN) && !out_stall;

  // latest cell holding the minimum: ties drop the later arrival
  always_comb begin
    low = '0;
    for (int i = 0; i < MAX_KEEP; i++) begin
      if (cell_hit[i]) low = idx_t'(i);
    end
  end

  // ---------------------------------------------------------------------------
  // Per-cell control: append at the tail, or close up over the dropped cell and
  // load the new word into the last occupied cell; a drain shifts everything
  // ---------------------------------------------------------------------------
  value_t new_value;
  pos_t   new_pos;

  assign new_value = (state == ST_IDLE) ? sample_value : hold_value;
  assign new_pos   = (state == ST_IDLE) ? arrival[POS_W-1:0] : hold_pos;

  always_comb begin
    for (int i = 0; i < MAX_KEEP; i++) begin
      ctrl[i].occupied = (count_t'(i) < count);
      ctrl[i].load     = (append && (count_t'(i) == count))
                      || (do_replace && (count_t'(i + 1) == count));
      ctrl[i].shift    = drain_take
                      || (do_replace && (idx_t'(i) >= low) && (count_t'(i + 1) < count));
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_KEEP; g++) begin : g_cell
      value_t nb_value;
      pos_t   nb_pos;
      if (g == MAX_KEEP - 1) begin : g_tail
        assign nb_value = KEY_FILL;
        assign nb_pos   = '0;
      end else begin : g_mid
        assign nb_value = cell_value[g+1];
        assign nb_pos   = cell_pos[g+1];
      end

      tkop_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl[g]),
        .new_value  (new_value),
        .new_pos    (new_pos),
        .next_value (nb_value),
        .next_pos   (nb_pos),
        .floor_min  (floor_min),
        .value      (cell_value[g]),
        .pos        (cell_pos[g]),
        .key        (cell_key[g]),
        .hit        (cell_hit[g])
      );
    end
  endgenerate

  tkop_min_tree u_min_tree (
    .clk     (clk),
    .keys    (cell_key),
    .min_key (floor_min)
  );

  // ---------------------------------------------------------------------------
  // Sequencer, count and arrival counter
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next   = state;
    count_next   = count;
    arrival_next = arrival;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (take) arrival_next = arrival + arrival_t'(1);
          if (append) count_next = count + count_t'(1);
          if (take && !room) begin
            state_next = ST_SCAN;
          end else if (end_of_set) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_SCAN: begin
        state_next = ST_REPLACE;
      end
      ST_REPLACE: begin
        state_next = hold_last ? ST_DRAIN : ST_IDLE;
      end
      ST_DRAIN: begin
        if (drain_take) begin
          count_next = count - count_t'(1);
          if (count == count_t'(1)) begin
            state_next   = ST_IDLE;
            arrival_next = '0;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      arrival <= '0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      arrival <= arrival_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_value <= sample_value;
      hold_pos   <= arrival[POS_W-1:0];
      hold_last  <= end_of_set;
    end
  end

  // ---------------------------------------------------------------------------
  // Output: cell 0 is the output register
  // ---------------------------------------------------------------------------
  assign out_valid       = (state == ST_DRAIN);
  assign chosen_value    = cell_value[0];
  assign chosen_position = cell_pos[0];
  assign final_result    = (count == count_t'(1));

`ifndef ASSERT_OFF
  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (count != '0))
    else $error("drain with empty store");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= count_t'(MAX_KEEP))
    else $error("store count above capacity");

  a_replace_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REPLACE) |=> (count == $past(count)))
    else $error("replacement changed store count");

  a_arrival_bound: assert property (@(posedge clk) disable iff (rst)
    arrival <= arrival_t'(MAX_LEN))
    else $error("arrival counter past limit");
`endif

endmodule

`default_nettype wire

FILE: src/tkop_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module tkop_cell (
  input  wire                  clk,
  input  tkop_pkg::cell_ctrl_t ctrl,
  input  tkop_pkg::value_t     new_value,
  input  tkop_pkg::pos_t       new_pos,
  input  tkop_pkg::value_t     next_value,
  input  tkop_pkg::pos_t       next_pos,
  input  tkop_pkg::value_t     floor_min,
  output tkop_pkg::value_t     value,
  output tkop_pkg::pos_t       pos,
  output tkop_pkg::value_t     key,
  output logic                 hit
);
  import tkop_pkg::*;

  // close-up from the right neighbor wins over a load
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= next_value;
      pos   <= next_pos;
    end else if (ctrl.load) begin
      value <= new_value;
      pos   <= new_pos;
    end
  end

  assign key = ctrl.occupied ? value : KEY_FILL;
  assign hit = ctrl.occupied && (value == floor_min);

endmodule

`default_nettype wire

FILE: src/tkop_min_tree.sv
`timescale 1ns / 1ps
`default_nettype none

module tkop_min_tree (
  input  wire              clk,
  input  tkop_pkg::value_t keys [tkop_pkg::MAX_KEEP],
  output tkop_pkg::value_t min_key
);
  import tkop_pkg::*;

  value_t group_min [NUM_GROUPS];
  value_t group_min_next [NUM_GROUPS];

  // before the register: reduce each group of eight, pairwise
  always_comb begin
    value_t lvl1 [GROUP_SIZE/2];
    value_t lvl2 [GROUP_SIZE/4];
    value_t leaf [GROUP_SIZE];
    for (int g = 0; g < NUM_GROUPS; g++) begin
      for (int j = 0; j < GROUP_SIZE; j++) begin
        leaf[j] = (g * GROUP_SIZE + j < MAX_KEEP) ? keys[g * GROUP_SIZE + j] : KEY_FILL;
      end
      for (int j = 0; j < GROUP_SIZE/2; j++) lvl1[j] = min2(leaf[2*j], leaf[2*j+1]);
      for (int j = 0; j < GROUP_SIZE/4; j++) lvl2[j] = min2(lvl1[2*j], lvl1[2*j+1]);
      group_min_next[g] = min2(lvl2[0], lvl2[1]);
    end
  end

  always_ff @(posedge clk) begin
    group_min <= group_min_next;
  end

  // after the register: reduce the group minima
  always_comb begin
    min_key = group_min[0];
    for (int g = 1; g < NUM_GROUPS; g++) min_key = min2(min_key, group_min[g]);
  end

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps

// Checks the order-preserving top-k selector: every word accepted on the
// input side is run through a local model of the keep store, and the words
// it should emit on an end-of-set are queued. Each output word is popped and
// compared field by field.
module testbench;
  import tkop_pkg::*;

  // one expected output word
  typedef struct {
    value_t value;
    pos_t   position;
    logic   last;
  } pick_t;

  logic   clk;
  logic   rst;
  logic   cfg_write;
  kc_t    cfg_data;
  logic   in_valid;
  logic   in_stall;
  value_t sample_value;
  logic   end_of_set;
  logic   out_valid;
  logic   out_stall;
  value_t chosen_value;
  pos_t   chosen_position;
  logic   final_result;

  top_k_order_preserving_select DUT (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .sample_value    (sample_value),
    .end_of_set      (end_of_set),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .chosen_value    (chosen_value),
    .chosen_position (chosen_position),
    .final_result    (final_result)
  );

  // Model of the keep store, updated once per accepted input word.
  kc_t   keep_reg = 1;
  int    kept_val [MAX_KEEP];
  int    kept_pos [MAX_KEEP];
  int    kept_n   = 0;
  int    arrivals = 0;
  pick_t picks_due [$];

  int mismatches   = 0;
  int idle_odds    = 4;  // sender gap chance 1 in N, 0 = never
  int stall_odds   = 4;  // receiver stall chance 1 in N, 0 = never
  int hold_request = 0;  // long receiver hold-off, in cycles

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (mismatches < 40) begin
      $display("MISMATCH at %0t: %s", $time, what);
    end
    mismatches++;
  endtask

  // k as the block applies it: zero acts as one, above MAX_KEEP saturates
  function automatic int keep_limit();
    int k;
    k = keep_reg;
    if (k == 0) k = 1;
    if (k > MAX_KEEP) k = MAX_KEEP;
    return k;
  endfunction

  // Apply one accepted sample to the store model and queue the words an
  // end-of-set releases.
  function automatic void absorb_sample(input value_t v, input logic last);
    int    low;
    pick_t p;
    if (arrivals < MAX_LEN) begin
      if (kept_n < keep_limit()) begin
        kept_val[kept_n] = v;
        kept_pos[kept_n] = arrivals;
        kept_n++;
      end else begin
        // smallest kept value, latest one on ties
        low = 0;
        for (int i = 1; i < kept_n; i++) begin
          if (kept_val[i] <= kept_val[low]) low = i;
        end
        if (int'(v) > kept_val[low]) begin
          for (int i = low; i + 1 < kept_n; i++) begin
            kept_val[i] = kept_val[i + 1];
            kept_pos[i] = kept_pos[i + 1];
          end
          kept_val[kept_n - 1] = v;
          kept_pos[kept_n - 1] = arrivals;
        end
      end
      arrivals++;
    end
    // past MAX_LEN the sample is dropped, but its end mark still counts
    if (last) begin
      for (int i = 0; i < kept_n; i++) begin
        p.value    = value_t'(kept_val[i]);
        p.position = pos_t'(kept_pos[i]);
        p.last     = (i == kept_n - 1);
        picks_due.insert(picks_due.size(), p);
      end
      kept_n   = 0;
      arrivals = 0;
    end
  endfunction

  function automatic value_t random_value(input int spread);
    int lim;
    lim = (spread == 0) ? 100000 : spread;
    return value_t'(int'($urandom_range(0, 2 * lim)) - lim);
  endfunction

  // Offer one word; valid stays up after acceptance so back-to-back words
  // need no extra assignment. A random gap drops valid first.
  task automatic send_sample(input value_t v, input logic last);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    sample_value <= v;
    end_of_set   <= last;
    do @(posedge clk); while (in_stall);
    absorb_sample(v, last);
  endtask

  // len samples; spread 0 = full range, else a narrow band to force ties
  task automatic send_set(input int len, input int spread, input logic close);
    for (int i = 0; i < len; i++) begin
      send_sample(random_value(spread), close && (i == len - 1));
    end
  endtask

  // Sender pause: wait for every queued word, then let the min tree settle
  // on any sample that produced no word.
  task automatic wait_for_picks();
    in_valid <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_keep(input kc_t k);
    wait_for_picks();
    cfg_write <= 1'b1;
    cfg_data  <= k;
    @(posedge clk);
    cfg_write <= 1'b0;
    keep_reg = k;
  endtask

  // Receiver: random stall bursts, or one long hold-off when asked.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        out_stall <= 1'b1;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
        out_stall <= 1'b0;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Output checker: values sampled at the edge are the pre-edge ones.
  always @(posedge clk) begin
    pick_t want;
    if (!rst && out_valid && !out_stall) begin
      if (picks_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word value %0d position %0d",
                                  chosen_value, chosen_position));
      end else begin
        want = picks_due.pop_front();
        if (chosen_value !== want.value)
          report_mismatch($sformatf("value %0d, want %0d", chosen_value, want.value));
        if (chosen_position !== want.position)
          report_mismatch($sformatf("position %0d, want %0d (value %0d)",
                                    chosen_position, want.position, want.value));
        if (final_result !== want.last)
          report_mismatch($sformatf("final_result %b, want %b (position %0d)",
                                    final_result, want.last, want.position));
      end
    end
  end

  // Reset value of k is 1: only the largest survives, earliest on ties.
  task automatic test_reset_keep();
    send_sample(7, 1'b0);
    send_sample(9, 1'b0);
    send_sample(9, 1'b0);
    send_sample(3, 1'b1);
    send_sample(-5, 1'b1);  // one-sample set
  endtask

  task automatic test_field_extremes();
    write_keep(4);
    send_sample(100000, 1'b0);
    send_sample(-100000, 1'b0);
    send_sample(0, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(1, 1'b0);
    send_sample(100000, 1'b0);
    send_sample(-100000, 1'b1);
  endtask

  // Equal values: earlier arrivals win, the latest minimum is dropped.
  task automatic test_ties();
    write_keep(3);
    send_sample(5, 1'b0);
    send_sample(5, 1'b0);
    send_sample(5, 1'b0);
    send_sample(5, 1'b0);
    send_sample(6, 1'b0);
    send_sample(5, 1'b0);
    send_sample(-2, 1'b1);
    send_sample(-7, 1'b0);
    send_sample(-7, 1'b0);
    send_sample(-7, 1'b0);
    send_sample(-7, 1'b1);
  endtask

  // k of zero acts as 1; k above MAX_KEEP saturates (full 32-word drain);
  // fewer samples than k emits them all.
  task automatic test_keep_extremes();
    write_keep(0);
    send_set(3, 0, 1'b1);
    write_keep(63);
    send_set(MAX_KEEP + 2, 0, 1'b1);
    write_keep(32);
    send_set(5, 0, 1'b1);
  endtask

  // k changed with a run open: shrinking below the store size, then growing.
  task automatic test_mid_run_keep();
    write_keep(6);
    send_set(8, 0, 1'b0);
    write_keep(2);
    send_set(4, 0, 1'b1);
    write_keep(2);
    send_set(4, 6, 1'b0);
    write_keep(5);
    send_set(5, 6, 1'b1);
  endtask

  // Run longer than MAX_LEN: late samples are ignored, the end mark is not.
  task automatic test_length_limit();
    write_keep(2);
    send_set(MAX_LEN - 2, 50000, 1'b0);
    send_sample(99999, 1'b0);
    send_sample(100000, 1'b0);
    repeat (5) send_sample(100000, 1'b0);
    send_sample(100000, 1'b1);
  endtask

  // Receiver held off long enough for the drain to back up into the input.
  task automatic test_backpressure();
    write_keep(16);
    hold_request = 400;
    repeat (3) send_set(20, 0, 1'b1);
    wait_for_picks();
  endtask

  task automatic test_random_sets();
    int sent;
    int len;
    int spread;
    int sel;
    sent = 0;
    while (sent < 460) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0: write_keep(0);
        1: write_keep(63);
        2: write_keep(kc_t'($urandom_range(33, 62)));
        default: write_keep(kc_t'($urandom_range(1, 32)));
      endcase
      sel = $urandom_range(0, 2);
      idle_odds = (sel == 0) ? 0 : (sel == 1) ? 3 : 10;
      sel = $urandom_range(0, 2);
      stall_odds = (sel == 0) ? 0 : (sel == 1) ? 3 : 10;
      repeat ($urandom_range(2, 6)) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 70)
                                          : $urandom_range(1, keep_limit() + 6);
        spread = ($urandom_range(0, 2) == 0) ? 4 : 0;
        if (len > 2 && $urandom_range(0, 5) == 0) begin
          // k changes partway through this set
          send_set(len / 2, spread, 1'b0);
          write_keep(kc_t'($urandom_range(0, 63)));
          send_set(len - len / 2, spread, 1'b1);
        end else begin
          send_set(len, spread, 1'b1);
        end
        sent += len;
      end
    end
  endtask

  // Last stretch: no gaps, no stalls, words back to back.
  task automatic test_steady_stream();
    write_keep(8);
    idle_odds  = 0;
    stall_odds = 0;
    repeat (4) send_set($urandom_range(8, 20), 0, 1'b1);
    send_set(6, 3, 1'b1);
  endtask

  initial begin
    rst          <= 1'b1;
    cfg_write    <= 1'b0;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    sample_value <= '0;
    end_of_set   <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_keep();
    test_field_extremes();
    test_ties();
    test_keep_extremes();
    test_mid_run_keep();
    test_length_limit();
    test_backpressure();
    test_random_sets();
    test_steady_stream();

    wait_for_picks();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
